/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication violated");

`endif

/* sv/egp_pkg.sv */
// Shared types and constants of the GBM Euler path payoff engine.
// No dependencies.
package egp_pkg;

  localparam int unsigned SPOT_W     = 32;
  localparam int unsigned SHOCK_W    = 16;
  localparam int unsigned COEF_W     = 31;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  // shared multiplier operand and rounded result widths
  localparam int unsigned MUL_A_W    = 34;
  localparam int unsigned MUL_B_W    = 32;
  localparam int unsigned RND_W      = 36;

  localparam logic [SPOT_W-1:0] SPOT_MAX       = '1;
  localparam logic [SPOT_W-1:0] START_SPOT_RST = 32'd6553600;
  localparam logic [SPOT_W-1:0] STRIKE_RST     = 32'd6553600;
  localparam logic [COEF_W-1:0] DISCOUNT_RST   = 31'd1073741824;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START_SPOT  = 3'd0,
    REG_DRIFT_DT    = 3'd1,
    REG_VOL_SQRT_DT = 3'd2,
    REG_STRIKE      = 3'd3,
    REG_IS_CALL     = 3'd4,
    REG_ANTITHETIC  = 3'd5,
    REG_DISCOUNT    = 3'd6
  } egp_reg_e;

  // rounding shift applied to a product
  typedef enum logic [1:0] {
    SH_13,
    SH_30,
    SH_31
  } egp_shift_e;

  typedef struct packed {
    logic        en;
    egp_shift_e  sh;
  } egp_mul_ctl_t;

  typedef struct packed {
    logic [SPOT_W-1:0]        start_spot;
    logic signed [SPOT_W-1:0] drift_dt;
    logic [COEF_W-1:0]        vol_sqrt_dt;
    logic [SPOT_W-1:0]        strike;
    logic                     is_call;
    logic                     antithetic_mode;
    logic [COEF_W-1:0]        discount;
  } egp_cfg_t;

endpackage

/* sv/egp_cfg.sv */
// Configuration register file of the path payoff engine.
// Depends on egp_pkg.
module egp_cfg
  import egp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output egp_cfg_t              cfg_o
);

  egp_cfg_t cfg_q;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_spot      <= START_SPOT_RST;
      cfg_q.drift_dt        <= '0;
      cfg_q.vol_sqrt_dt     <= '0;
      cfg_q.strike          <= STRIKE_RST;
      cfg_q.is_call         <= 1'b1;
      cfg_q.antithetic_mode <= 1'b0;
      cfg_q.discount        <= DISCOUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_START_SPOT:  cfg_q.start_spot      <= cfg_wdata_i;
        REG_DRIFT_DT:    cfg_q.drift_dt        <= cfg_wdata_i;
        REG_VOL_SQRT_DT: cfg_q.vol_sqrt_dt     <= cfg_wdata_i[COEF_W-1:0];
        REG_STRIKE:      cfg_q.strike          <= cfg_wdata_i;
        REG_IS_CALL:     cfg_q.is_call         <= cfg_wdata_i[0];
        REG_ANTITHETIC:  cfg_q.antithetic_mode <= cfg_wdata_i[0];
        REG_DISCOUNT:    cfg_q.discount        <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/egp_mul.sv */
// Shared multiply unit: registered unsigned product, then round half up
// and shift right by a selectable amount. Depends on egp_pkg.
module egp_mul
  import egp_pkg::*;
(
  input  logic               clk_i,
  input  egp_mul_ctl_t       ctl_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [RND_W-1:0]   rnd_o
);

  localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;

  logic [PROD_W-1:0] prod_q;
  logic [PROD_W:0]   rnd_wide;

  // product register, loaded when the sequencer issues an operation
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      prod_q <= a_i * b_i;
    end
  end

  // round half up on the magnitude, then shift
  always_comb begin
    unique case (ctl_i.sh)
      SH_13:   rnd_wide = ({1'b0, prod_q} + ((PROD_W+1)'(1) << 12)) >> 13;
      SH_31:   rnd_wide = ({1'b0, prod_q} + ((PROD_W+1)'(1) << 30)) >> 31;
      default: rnd_wide = ({1'b0, prod_q} + ((PROD_W+1)'(1) << 29)) >> 30;
    endcase
  end

  assign rnd_o = rnd_wide[RND_W-1:0];

endmodule

/* sv/euler_gbm_path_payoff.sv */
// Channel   Dir  Width  Contents
// s_axis    in   16+1   tdata: normal_shock; tlast: last_step
// m_axis    out  64     tdata: payoff_sample, terminal_spot
// cfg       in   3+32   register index, write data
//
// The engine takes no new shock until it is done with the last one and is back
// in idle; the last step of a path also waits for the output register. Six
// multiplications per step (drift, volatility, shock for each path) and one
// for the payoff pass through the single multiplier.
// Reset loads the register defaults and the start spot into both paths.
// A held result stalls only the final payoff write-back.
// Top level of the GBM Euler path payoff engine.
// Depends on egp_pkg, egp_cfg and egp_mul.
module euler_gbm_path_payoff
  import egp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SHOCK_W-1:0]    s_axis_tdata,   // [15:0] normal_shock
  input  logic                  s_axis_tlast,   // last_step
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*SPOT_W-1:0]   m_axis_tdata    // [31:0] payoff_sample, [63:32] terminal_spot
);

  localparam int unsigned ACC_W = RND_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_PREP,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_D_PLUS,
    OP_T_PLUS,
    OP_V_PLUS,
    OP_D_MINUS,
    OP_T_MINUS,
    OP_V_MINUS,
    OP_PAY
  } op_e;

  egp_cfg_t     cfg;
  egp_mul_ctl_t mul_ctl;
  state_e       state_q;
  op_e          op_q;

  logic [SPOT_W-1:0]        plus_q, minus_q;
  logic                     m_valid_q;
  logic [2*SPOT_W-1:0]      m_data_q;
  logic [SHOCK_W-1:0]       zmag_q;
  logic                     zneg_q, last_q;
  logic signed [ACC_W-1:0]  acc_q, acc_step;
  logic [MUL_A_W-1:0]       t_q, mul_a;
  logic [SPOT_W:0]          p_q;
  logic [SPOT_W-1:0]        pay_q;
  logic [MUL_B_W-1:0]       mul_b;
  logic [RND_W-1:0]         rnd;
  logic [SPOT_W-1:0]        dmag, van_plus, van_minus, step_spot;
  logic                     dneg, v_sub, start_wr, out_free;

  // clamp a signed spot to the unsigned Q16.16 range
  function automatic logic [SPOT_W-1:0] clamp_spot(input logic signed [ACC_W-1:0] x);
    logic [SPOT_W-1:0] r;
    if (x <= 0) begin
      r = '0;
    end else if (x[ACC_W-1:SPOT_W] != '0) begin
      r = SPOT_MAX;
    end else begin
      r = x[SPOT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [SPOT_W-1:0] vanilla(input logic [SPOT_W-1:0] s,
                                                input logic [SPOT_W-1:0] k,
                                                input logic call);
    logic [SPOT_W-1:0] r;
    if (call) begin
      r = (s > k) ? s - k : '0;
    end else begin
      r = (k > s) ? k - s : '0;
    end
    return r;
  endfunction

  egp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // drift magnitude; the most negative value gives 2^31 unwrapped
  assign dneg = cfg.drift_dt[SPOT_W-1];
  assign dmag = dneg ? (~cfg.drift_dt + 1'b1) : cfg.drift_dt;

  assign step_spot = (op_q == OP_D_PLUS || op_q == OP_T_PLUS) ? plus_q : minus_q;

  // operand select for the shared multiplier
  always_comb begin
    mul_ctl.en = (state_q == ST_MUL);
    mul_ctl.sh = SH_30;
    unique case (op_q)
      OP_D_PLUS, OP_D_MINUS: begin
        mul_a = {2'b0, dmag};
        mul_b = step_spot;
      end
      OP_T_PLUS, OP_T_MINUS: begin
        mul_a = {3'b0, cfg.vol_sqrt_dt};
        mul_b = step_spot;
      end
      OP_V_PLUS, OP_V_MINUS: begin
        mul_a = t_q;
        mul_b = {16'b0, zmag_q};
        mul_ctl.sh = SH_13;
      end
      default: begin
        mul_a = {1'b0, p_q};
        mul_b = {1'b0, cfg.discount};
        mul_ctl.sh = cfg.antithetic_mode ? SH_31 : SH_30;
      end
    endcase
  end

  egp_mul u_mul (
    .clk_i (clk_i),
    .ctl_i (mul_ctl),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .rnd_o (rnd)
  );

  // shock term: minus path sees the mirrored sign
  assign v_sub    = (op_q == OP_V_PLUS) ? zneg_q : !zneg_q;
  assign acc_step = v_sub ? acc_q - $signed({2'b0, rnd}) : acc_q + $signed({2'b0, rnd});

  assign van_plus  = vanilla(plus_q, cfg.strike, cfg.is_call);
  assign van_minus = vanilla(minus_q, cfg.strike, cfg.is_call);
  assign start_wr  = cfg_we_i && (cfg_addr_i == REG_START_SPOT);
  assign out_free  = !m_valid_q || m_axis_tready;

  // sequencer, spot state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_D_PLUS;
      plus_q    <= START_SPOT_RST;
      minus_q   <= START_SPOT_RST;
      m_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= OP_D_PLUS;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_RND;
        ST_RND: begin
          unique case (op_q)
            OP_D_PLUS: begin
              op_q    <= OP_T_PLUS;
              state_q <= ST_MUL;
            end
            OP_T_PLUS: begin
              op_q    <= OP_V_PLUS;
              state_q <= ST_MUL;
            end
            OP_V_PLUS: begin
              op_q    <= OP_D_MINUS;
              state_q <= ST_MUL;
            end
            OP_D_MINUS: begin
              op_q    <= OP_T_MINUS;
              state_q <= ST_MUL;
            end
            OP_T_MINUS: begin
              op_q    <= OP_V_MINUS;
              state_q <= ST_MUL;
            end
            OP_V_MINUS: state_q <= last_q ? ST_PREP : ST_IDLE;
            default:    state_q <= ST_OUT;
          endcase
        end
        ST_PREP: begin
          op_q    <= OP_PAY;
          state_q <= ST_MUL;
        end
        default: begin
          // wait for a free output register
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
      endcase

      // output valid: posted from the payoff state, dropped on a transfer out
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      // spot registers; a start spot write or a posted payoff restarts both paths
      if (start_wr) begin
        plus_q  <= cfg_wdata_i;
        minus_q <= cfg_wdata_i;
      end else if (state_q == ST_OUT && out_free) begin
        plus_q  <= cfg.start_spot;
        minus_q <= cfg.start_spot;
      end else if (state_q == ST_RND && op_q == OP_V_PLUS) begin
        plus_q <= clamp_spot(acc_step);
      end else if (state_q == ST_RND && op_q == OP_V_MINUS) begin
        minus_q <= clamp_spot(acc_step);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      zneg_q <= s_axis_tdata[SHOCK_W-1];
      zmag_q <= s_axis_tdata[SHOCK_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    if (state_q == ST_RND) begin
      if (op_q == OP_D_PLUS || op_q == OP_D_MINUS) begin
        acc_q <= dneg ? $signed({6'b0, step_spot}) - $signed({2'b0, rnd})
                      : $signed({6'b0, step_spot}) + $signed({2'b0, rnd});
      end
      if (op_q == OP_T_PLUS || op_q == OP_T_MINUS) begin
        t_q <= rnd[MUL_A_W-1:0];
      end
      if (op_q == OP_PAY) begin
        pay_q <= (rnd[RND_W-1:SPOT_W] != '0) ? SPOT_MAX : rnd[SPOT_W-1:0];
      end
    end
    if (state_q == ST_PREP) begin
      p_q <= cfg.antithetic_mode ? {1'b0, van_plus} + {1'b0, van_minus}
                                 : {1'b0, van_plus};
    end
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= {plus_q, pay_q};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* sv/egp_checker.sv */
// Port-level checks of the path payoff engine, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module egp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // a waiting result is held with its data
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // the engine is busy right after taking a shock
  `ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // no result can appear in the cycle after a transfer in
  `ASSERT_NEXT(a_no_fast_out, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))
  // a new result is posted as the engine returns to idle
  `ASSERT_SAME(a_out_at_idle, clk_i, rst_ni, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind euler_gbm_path_payoff egp_checker u_egp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/euler_gbm_path_payoff_tb.sv */
// Self-checking testbench for the GBM Euler path payoff engine: directed table, then random paths.
// Holds its own bit-exact model of the spot recurrence and payoff and checks every output transfer.
// Depends on egp_pkg and euler_gbm_path_payoff.
`timescale 1ns / 100ps

module euler_gbm_path_payoff_tb;
  import egp_pkg::*;

  localparam int SETTLE_CYCLES   = 40;    // worst case step latency plus margin
  localparam int HOLD_CYCLES     = 400;   // long output back-pressure stretch
  localparam int STALL_LIMIT     = 4000;  // cycles with no transfer before giving up
  localparam int RAND_PHASES     = 13;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int N_DIR           = 34;

  // index outside the register map, must be ignored
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [SPOT_W-1:0] pay;
    logic [SPOT_W-1:0] spot;
  } payoff_rec_t;

  typedef enum logic {ROW_STEP, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_ADDR_W-1:0] idx;    // register index for writes
    logic [CFG_DATA_W-1:0] value;  // write data, or the shock in the low bits
    logic                  last;
    logic                  typed;  // expected result given below, not predicted
    logic [SPOT_W-1:0]     pay;
    logic [SPOT_W-1:0]     spot;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SHOCK_W-1:0]    s_axis_tdata;   // [15:0] normal_shock
  logic                  s_axis_tlast;   // last_step
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [2*SPOT_W-1:0]   m_axis_tdata;   // [31:0] payoff_sample, [63:32] terminal_spot

  // model state
  egp_cfg_t          model_cfg;
  logic [SPOT_W-1:0] spot_up;
  logic [SPOT_W-1:0] spot_dn;
  payoff_rec_t       payoffs_due[$];

  int   mismatches   = 0;
  int   stall_cnt    = 0;
  bit   in_idle_en   = 1'b1;
  bit   out_idle_en  = 1'b1;
  bit   out_hold_req = 1'b0;

  dir_row_t dir_rows [N_DIR] = '{
    // reset settings: flat path, at the money
    '{ROW_STEP,  3'd0,            32'h0000_7FFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_8000, 1'b1, 1'b1, 32'h0, START_SPOT_RST},
    '{ROW_STEP,  3'd0,            32'h0000_0000, 1'b1, 1'b1, 32'h0, START_SPOT_RST},
    // zero strike: call pays the spot
    '{ROW_WRITE, REG_STRIKE,      32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_1234, 1'b1, 1'b1, START_SPOT_RST, START_SPOT_RST},
    '{ROW_WRITE, REG_DISCOUNT,    32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_FFFF, 1'b1, 1'b1, 32'h0, START_SPOT_RST},
    // discount above one, top spot: payoff saturates
    '{ROW_WRITE, REG_DISCOUNT,    32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_START_SPOT,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{ROW_WRITE, REG_IS_CALL,     32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_0001, 1'b1, 1'b1, 32'h0, 32'hFFFF_FFFF},
    '{ROW_WRITE, REG_START_SPOT,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_STRIKE,      32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_8000, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0},
    // extreme coefficients, checked by the model
    '{ROW_WRITE, REG_DISCOUNT,    32'h4000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_START_SPOT,  START_SPOT_RST, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_STRIKE,      START_SPOT_RST, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_VOL_SQRT_DT, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_DRIFT_DT,    32'h8000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_8000, 1'b0, 1'b0, 32'h0, 32'h0},
    // antithetic switched on mid-path: mirror path was advanced all along
    '{ROW_WRITE, REG_ANTITHETIC,  32'h0000_0001, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_8000, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_DRIFT_DT,    32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_7FFF, 1'b0, 1'b0, 32'h0, 32'h0},
    // start spot write restarts the running path
    '{ROW_WRITE, REG_START_SPOT,  START_SPOT_RST, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_C000, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_UNUSED,      32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_0000, 1'b1, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_IS_CALL,     32'h0000_0001, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_DRIFT_DT,    32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_VOL_SQRT_DT, 32'h0800_0000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_0800, 1'b0, 1'b0, 32'h0, 32'h0},
    '{ROW_STEP,  3'd0,            32'h0000_F800, 1'b1, 1'b0, 32'h0, 32'h0}
  };

  euler_gbm_path_payoff uut (.*);

  // clock, 10 ns period
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one Euler step of a spot, rounding half away from zero on magnitudes
  function automatic logic [SPOT_W-1:0] euler_advance(logic [SPOT_W-1:0] s, logic zneg,
                                                       logic [16:0] zmag);
    logic              dneg;
    logic [SPOT_W-1:0] draw;
    longint unsigned   dmag;
    longint unsigned   dterm;
    longint unsigned   tterm;
    longint unsigned   vterm;
    longint            nxt;
    draw  = model_cfg.drift_dt;
    dneg  = draw[SPOT_W-1];
    dmag  = dneg ? (64'h1_0000_0000 - 64'(draw)) : 64'(draw);
    dterm = (dmag * 64'(s) + (64'd1 << 29)) >> 30;
    tterm = (64'(model_cfg.vol_sqrt_dt) * 64'(s) + (64'd1 << 29)) >> 30;
    vterm = (tterm * 64'(zmag) + (64'd1 << 12)) >> 13;
    nxt   = longint'(s);
    nxt   = dneg ? nxt - longint'(dterm) : nxt + longint'(dterm);
    nxt   = zneg ? nxt - longint'(vterm) : nxt + longint'(vterm);
    if (nxt <= 0) return '0;
    if (nxt > longint'(SPOT_MAX)) return SPOT_MAX;
    return nxt[SPOT_W-1:0];
  endfunction

  function automatic logic [63:0] intrinsic_value(logic [SPOT_W-1:0] s);
    if (model_cfg.is_call) return (s > model_cfg.strike) ? 64'(s - model_cfg.strike) : 64'd0;
    return (model_cfg.strike > s) ? 64'(model_cfg.strike - s) : 64'd0;
  endfunction

  function automatic logic [SPOT_W-1:0] discounted_payoff();
    logic [79:0] prod;
    if (model_cfg.antithetic_mode)
      prod = (80'(model_cfg.discount) * (80'(intrinsic_value(spot_up)) +
              80'(intrinsic_value(spot_dn))) + (80'd1 << 30)) >> 31;
    else
      prod = (80'(model_cfg.discount) * 80'(intrinsic_value(spot_up)) + (80'd1 << 29)) >> 30;
    return (prod > 80'(SPOT_MAX)) ? SPOT_MAX : prod[SPOT_W-1:0];
  endfunction

  // advance both paths for one accepted shock; queue the payoff on the last step
  task automatic predict_shock(logic [SHOCK_W-1:0] z, logic last, logic typed,
                               logic [SPOT_W-1:0] tpay, logic [SPOT_W-1:0] tspot);
    logic        zneg;
    logic [16:0] zmag;
    payoff_rec_t rec;
    zneg    = z[SHOCK_W-1];
    zmag    = zneg ? (17'h1_0000 - 17'(z)) : 17'(z);
    spot_up = euler_advance(spot_up, zneg, zmag);
    spot_dn = euler_advance(spot_dn, (zmag != 0) && !zneg, zmag);
    if (last) begin
      rec.pay  = typed ? tpay : discounted_payoff();
      rec.spot = typed ? tspot : spot_up;
      payoffs_due = {payoffs_due, rec};
      spot_up = model_cfg.start_spot;
      spot_dn = model_cfg.start_spot;
    end
  endtask

  task automatic apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_START_SPOT: begin
        model_cfg.start_spot = value;
        spot_up = value;
        spot_dn = value;
      end
      REG_DRIFT_DT:    model_cfg.drift_dt        = value;
      REG_VOL_SQRT_DT: model_cfg.vol_sqrt_dt     = value[COEF_W-1:0];
      REG_STRIKE:      model_cfg.strike          = value;
      REG_IS_CALL:     model_cfg.is_call         = value[0];
      REG_ANTITHETIC:  model_cfg.antithetic_mode = value[0];
      REG_DISCOUNT:    model_cfg.discount        = value[COEF_W-1:0];
      default: ;
    endcase
  endtask

  // register write; only called with the block idle
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    apply_reg(idx, value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for all payoffs, then for any path step still in flight
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (payoffs_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // offer one shock, with random idle cycles, and predict on the transfer
  task automatic send_shock(logic [SHOCK_W-1:0] z, logic last, logic typed,
                            logic [SPOT_W-1:0] tpay, logic [SPOT_W-1:0] tspot);
    while (in_idle_en && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= z;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    predict_shock(z, last, typed, tpay, tspot);
  endtask

  // mostly moderate shocks, a quarter over the whole 16-bit range
  function automatic logic [SHOCK_W-1:0] draw_shock();
    int unsigned k;
    if ($urandom_range(3) == 0) return SHOCK_W'($urandom);
    k = $urandom_range(0, 32768);
    return SHOCK_W'(k - 16384);
  endfunction

  // output side: random back-pressure, plus one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (out_hold_req) begin
        out_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= !out_idle_en || ($urandom_range(99) >= 32);
      @(posedge clk_i);
    end
  end

  // result check against the oldest queued payoff
  always @(posedge clk_i) begin : payoff_check
    payoff_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (payoffs_due.size() == 0) begin
        $error("payoff transfer with nothing queued, tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = payoffs_due.pop_front();
        if (m_axis_tdata[SPOT_W-1:0] !== want.pay) begin
          $error("payoff_sample: expected %h, got %h", want.pay, m_axis_tdata[SPOT_W-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[2*SPOT_W-1:SPOT_W] !== want.spot) begin
          $error("terminal_spot: expected %h, got %h", want.spot,
                 m_axis_tdata[2*SPOT_W-1:SPOT_W]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer or register write
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("euler_gbm_path_payoff_tb: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned           path_left;
    logic [SPOT_W-1:0]     pick_start;
    logic [CFG_DATA_W-1:0] pick;
    bit                    partial;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;

    model_cfg.start_spot      = START_SPOT_RST;
    model_cfg.drift_dt        = '0;
    model_cfg.vol_sqrt_dt     = '0;
    model_cfg.strike          = STRIKE_RST;
    model_cfg.is_call         = 1'b1;
    model_cfg.antithetic_mode = 1'b0;
    model_cfg.discount        = DISCOUNT_RST;
    spot_up = START_SPOT_RST;
    spot_dn = START_SPOT_RST;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        settle_block();
        write_reg(dir_rows[r].idx, dir_rows[r].value);
      end else begin
        send_shock(dir_rows[r].value[SHOCK_W-1:0], dir_rows[r].last, dir_rows[r].typed,
                   dir_rows[r].pay, dir_rows[r].spot);
      end
    end

    // random phases: new settings, then well-formed paths of random length
    path_left = 0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_block();
      partial = (ph % 4 == 3);

      case ($urandom_range(9))
        0:       pick_start = '0;
        1:       pick_start = SPOT_MAX;
        2:       pick_start = $urandom;
        default: pick_start = 32'($urandom_range(20, 500)) << 16;
      endcase
      if (!partial || $urandom_range(1)) write_reg(REG_START_SPOT, pick_start);

      case ($urandom_range(9))
        0:       pick = 32'h8000_0000;
        1:       pick = 32'h7FFF_FFFF;
        2:       pick = $urandom;
        default: pick = 32'($urandom_range(0, 1 << 24)) - (32'd1 << 23);
      endcase
      if (!partial || $urandom_range(1)) write_reg(REG_DRIFT_DT, pick);

      case ($urandom_range(9))
        0:       pick = '0;
        1:       pick = 32'h7FFF_FFFF;
        default: pick = 32'($urandom_range(0, 1 << 27));
      endcase
      pick[31] = 1'($urandom_range(1));  // unused top bit must be dropped
      if (!partial || $urandom_range(1)) write_reg(REG_VOL_SQRT_DT, pick);

      case ($urandom_range(9))
        0:       pick = '0;
        1:       pick = SPOT_MAX;
        2:       pick = $urandom;
        default: pick = model_cfg.start_spot + 32'($urandom_range(0, 1 << 21)) - (32'd1 << 20);
      endcase
      if (!partial || $urandom_range(1)) write_reg(REG_STRIKE, pick);

      if (!partial || $urandom_range(1)) write_reg(REG_IS_CALL, $urandom);
      if (!partial || $urandom_range(1)) write_reg(REG_ANTITHETIC, $urandom);

      case ($urandom_range(9))
        0:       pick = '0;
        1:       pick = 32'h7FFF_FFFF;
        2:       pick = 32'($urandom_range(0, 1 << 30));
        default: pick = 32'($urandom_range(1 << 29, 1 << 30));
      endcase
      pick[31] = 1'($urandom_range(1));
      if (!partial || $urandom_range(1)) write_reg(REG_DISCOUNT, pick);

      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom);

      // one phase without idling; two phases open with a long output hold
      in_idle_en  = (ph != 4);
      out_idle_en = (ph != 4);
      if (ph == 1 || ph == 8) out_hold_req = 1'b1;

      // paths run across phase boundaries, so settings change mid-path too
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (path_left == 0)
          path_left = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
        path_left--;
        send_shock(draw_shock(), path_left == 0, 1'b0, '0, '0);
      end
    end

    settle_block();
    if (mismatches == 0)
      $display("euler_gbm_path_payoff_tb: done, clean");
    else
      $display("euler_gbm_path_payoff_tb: done, errors");
    $finish;
  end

endmodule
